@@ rtl/owbm_pkg.sv @@
// Package: shared types, codes and register defaults of the 1-Wire bus master.
`default_nettype none
package owbm_pkg;

  localparam int unsigned REG_W     = 10;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_RELEASE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_RELEASE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 4'd7;

  localparam logic [REG_W-1:0] READ_RECOVER_TICKS = 10'd60;

  typedef logic [REG_W-1:0] reg_val_t;
  typedef reg_val_t [NUM_REGS-1:0] reg_file_t;

  localparam reg_file_t REG_DEFAULTS = {
    10'd12, 10'd2, 10'd2, 10'd60, 10'd60, 10'd3, 10'd200, 10'd500
  };

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] write_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic       is_cmd;
    logic [1:0] op;
    logic [7:0] write_byte;
    logic       line_level;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

  function automatic reg_val_t dur(input reg_val_t v);
    dur = (v == '0) ? reg_val_t'(1) : v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/owbm_front.sv @@
// Front part: accepts ticks, classifies them and queues them for the back part.
`default_nettype none
module owbm_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  output logic                in_full,
  input  owbm_pkg::in_item_t  in_data,
  output owbm_pkg::cmd_q_t    cmd_q,
  input  wire                 cmd_pop
);

  owbm_pkg::cmd_t q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  owbm_pkg::cmd_t cls;

  always_comb begin
    cls.is_cmd     = (in_data.req_type != owbm_pkg::OP_TICK);
    cls.op         = in_data.req_type;
    cls.write_byte = in_data.write_byte;
    cls.line_level = in_data.line_level;
  end

  assign in_full = (cnt_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign do_pop  = cmd_pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  assign cmd_q.valid = (cnt_r != 2'd0);
  assign cmd_q.cmd   = q_mem[rd_ptr_r];

endmodule
`default_nettype wire

@@ rtl/owbm_back.sv @@
// Back part: register file, bus timing state and the result queue.
`default_nettype none
module owbm_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  owbm_pkg::cmd_q_t                   cmd_q,
  output logic                               cmd_pop,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [owbm_pkg::REG_W-1:0]          cfg_data,
  output logic                               out_empty,
  input  wire                                out_pop,
  output owbm_pkg::out_item_t                out_data
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LOW     = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;
  localparam logic [1:0] PH_RECOVER = 2'd3;

  owbm_pkg::reg_file_t regs_r;
  logic [1:0]               phase_r, phase_nxt;
  owbm_pkg::reg_val_t       timer_r, timer_nxt;
  logic [2:0]               bit_r, bit_nxt;
  logic [7:0]               shift_r, shift_nxt;
  logic [1:0]               op_r, op_nxt;
  logic                     drv_r, drv_nxt;
  logic [7:0]               hold_r, hold_nxt;
  logic                     done, rej;
  owbm_pkg::reg_val_t       t_dec;
  logic [7:0]               sh;
  owbm_pkg::out_item_t      res;

  owbm_pkg::out_item_t o_mem [2];
  logic       o_wr_r, o_rd_r;
  logic [1:0] o_cnt_r;
  logic       o_room, step, o_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= owbm_pkg::REG_DEFAULTS;
    end else if (cfg_valid && cfg_index < owbm_pkg::CFG_IDX_W'(owbm_pkg::NUM_REGS)) begin
      regs_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign o_room  = (o_cnt_r != 2'd2);
  assign step    = cmd_q.valid && o_room;
  assign cmd_pop = step;
  assign o_pop   = out_pop && (o_cnt_r != 2'd0);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    op_nxt    = op_r;
    drv_nxt   = drv_r;
    hold_nxt  = hold_r;
    done      = 1'b0;
    rej       = 1'b0;
    t_dec     = timer_r - owbm_pkg::REG_W'(timer_r != '0);
    sh        = shift_r >> 1;
    if (phase_r != PH_IDLE) begin
      rej       = cmd_q.cmd.is_cmd;
      timer_nxt = t_dec;
      if (t_dec == '0) begin
        priority if (op_r == owbm_pkg::OP_RESET && phase_r == PH_LOW) begin
          phase_nxt = PH_RELEASE;
          timer_nxt = owbm_pkg::dur(regs_r[owbm_pkg::REG_RESET_RELEASE[2:0]]);
          drv_nxt   = 1'b0;
        end else if (op_r == owbm_pkg::OP_RESET && phase_r == PH_RELEASE) begin
          phase_nxt = PH_IDLE; timer_nxt = '0; bit_nxt = '0; drv_nxt = 1'b0;
          done      = 1'b1;
        end else if (op_r == owbm_pkg::OP_WRITE && phase_r == PH_LOW) begin
          phase_nxt = PH_RELEASE;
          timer_nxt = shift_r[0] ?
                      owbm_pkg::dur(regs_r[owbm_pkg::REG_ONE_RELEASE[2:0]]) :
                      owbm_pkg::dur(regs_r[owbm_pkg::REG_ZERO_RELEASE[2:0]]);
          drv_nxt   = 1'b0;
        end else if (op_r == owbm_pkg::OP_WRITE && phase_r == PH_RELEASE) begin
          shift_nxt = sh;
          if (bit_r == 3'd7) begin
            phase_nxt = PH_IDLE; timer_nxt = '0; bit_nxt = '0; drv_nxt = 1'b0;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_LOW;
            timer_nxt = sh[0] ?
                        owbm_pkg::dur(regs_r[owbm_pkg::REG_ONE_LOW[2:0]]) :
                        owbm_pkg::dur(regs_r[owbm_pkg::REG_ZERO_LOW[2:0]]);
            drv_nxt   = 1'b1;
          end
        end else if (op_r == owbm_pkg::OP_READ && phase_r == PH_LOW) begin
          phase_nxt = PH_RELEASE;
          timer_nxt = owbm_pkg::dur(regs_r[owbm_pkg::REG_READ_SAMPLE[2:0]]);
          drv_nxt   = 1'b0;
        end else if (op_r == owbm_pkg::OP_READ && phase_r == PH_RELEASE) begin
          shift_nxt = {cmd_q.cmd.line_level, shift_r[7:1]};
          phase_nxt = PH_RECOVER;
          timer_nxt = owbm_pkg::READ_RECOVER_TICKS;
          drv_nxt   = 1'b0;
        end else if (op_r == owbm_pkg::OP_READ && phase_r == PH_RECOVER) begin
          if (bit_r == 3'd7) begin
            hold_nxt  = shift_r;
            phase_nxt = PH_IDLE; timer_nxt = '0; bit_nxt = '0; drv_nxt = 1'b0;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_LOW;
            timer_nxt = owbm_pkg::dur(regs_r[owbm_pkg::REG_READ_LOW[2:0]]);
            drv_nxt   = 1'b1;
          end
        end else begin
          phase_nxt = PH_IDLE; timer_nxt = '0; bit_nxt = '0; drv_nxt = 1'b0;
        end
      end
    end else if (cmd_q.cmd.is_cmd) begin
      op_nxt    = cmd_q.cmd.op;
      bit_nxt   = '0;
      phase_nxt = PH_LOW;
      drv_nxt   = 1'b1;
      unique case (cmd_q.cmd.op)
        owbm_pkg::OP_RESET: begin
          timer_nxt = owbm_pkg::dur(regs_r[owbm_pkg::REG_RESET_LOW[2:0]]);
        end
        owbm_pkg::OP_WRITE: begin
          shift_nxt = cmd_q.cmd.write_byte;
          timer_nxt = cmd_q.cmd.write_byte[0] ?
                      owbm_pkg::dur(regs_r[owbm_pkg::REG_ONE_LOW[2:0]]) :
                      owbm_pkg::dur(regs_r[owbm_pkg::REG_ZERO_LOW[2:0]]);
        end
        default: begin
          shift_nxt = '0;
          timer_nxt = owbm_pkg::dur(regs_r[owbm_pkg::REG_READ_LOW[2:0]]);
        end
      endcase
    end
  end

  always_comb begin
    res.drive_low = drv_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.read_data = hold_nxt;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      op_r    <= owbm_pkg::OP_TICK;
      drv_r   <= 1'b0;
      hold_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      op_r    <= op_nxt;
      drv_r   <= drv_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_wr_r  <= 1'b0;
      o_rd_r  <= 1'b0;
      o_cnt_r <= 2'd0;
    end else begin
      if (step) begin
        o_wr_r <= ~o_wr_r;
      end
      if (o_pop) begin
        o_rd_r <= ~o_rd_r;
      end
      o_cnt_r <= o_cnt_r + 2'(step) - 2'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_mem[o_wr_r] <= res;
    end
  end

  assign out_empty = (o_cnt_r == 2'd0);
  assign out_data  = o_mem[o_rd_r];

endmodule
`default_nettype wire

@@ rtl/onewire_bus_master_unit.sv @@
// Top level: 1-Wire bus master, front queue feeding the timing engine.
//
//  channel  ports                               handshake
//  in       in_push, in_full, in_data           push & !full
//  out      out_pop, out_empty, out_data        pop & !empty
//  cfg      cfg_valid, cfg_ready, cfg_index,    valid & ready
//           cfg_data
//
// One tick item is taken per cycle while in_full is low; its result passes
// through the front queue and then the result queue before the out ports;
// the engine writes the result queue on the edge it steps.
// The timing engine updates its state on each tick it takes from the front queue.
// Reset restores register defaults and leaves the bus released and idle.
// A full result queue stalls the engine; the front queue then fills and
// raises in_full.
`default_nettype none
module onewire_bus_master_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_push,
  output logic                           in_full,
  input  owbm_pkg::in_item_t             in_data,
  output logic                           out_empty,
  input  wire                            out_pop,
  output owbm_pkg::out_item_t            out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [owbm_pkg::REG_W-1:0]      cfg_data
);

  owbm_pkg::cmd_q_t cmd_q;
  logic             cmd_pop;

  owbm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cmd_q   (cmd_q),
    .cmd_pop (cmd_pop)
  );

  owbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_q     (cmd_q),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
